>>> hdl/tlcc_pkg.sv
// Shared types, register indexes and seven-segment helpers for the traffic light controller.
package tlcc_pkg;

    // Phase sequencer states, one-hot
    typedef enum logic [3:0] {
        PH_A_GREEN  = 4'b0001,
        PH_A_YELLOW = 4'b0010,
        PH_B_GREEN  = 4'b0100,
        PH_B_YELLOW = 4'b1000
    } phase_t;

    // Phase codes as reported on the result stream
    localparam logic [1:0] PHASE_CODE_A_GREEN  = 2'd0;
    localparam logic [1:0] PHASE_CODE_A_YELLOW = 2'd1;
    localparam logic [1:0] PHASE_CODE_B_GREEN  = 2'd2;
    localparam logic [1:0] PHASE_CODE_B_YELLOW = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_GREEN_SECONDS  = 3'd0;
    localparam logic [2:0] CFG_YELLOW_SECONDS = 3'd1;
    localparam logic [2:0] CFG_RED_SECONDS    = 3'd2;
    localparam logic [2:0] CFG_LAMPS_A_GREEN  = 3'd3;
    localparam logic [2:0] CFG_LAMPS_A_YELLOW = 3'd4;
    localparam logic [2:0] CFG_LAMPS_B_GREEN  = 3'd5;
    localparam logic [2:0] CFG_LAMPS_B_YELLOW = 3'd6;

    // Register reset values
    localparam logic [6:0] GREEN_SECONDS_RST  = 7'd26;
    localparam logic [6:0] YELLOW_SECONDS_RST = 7'd2;
    localparam logic [6:0] RED_SECONDS_RST    = 7'd29;
    localparam logic [7:0] LAMPS_A_GREEN_RST  = 8'd17;
    localparam logic [7:0] LAMPS_A_YELLOW_RST = 8'd20;
    localparam logic [7:0] LAMPS_B_GREEN_RST  = 8'd10;
    localparam logic [7:0] LAMPS_B_YELLOW_RST = 8'd34;

    // All segments off
    localparam logic [7:0] SEG_BLANK = 8'hFF;

    // Reciprocal of ten for a 7-bit value: (v * 205) >> 11
    localparam logic [14:0] RECIP_TEN   = 15'd205;
    localparam int          RECIP_SHIFT = 11;

    // Tens and ones segment codes of one counter
    typedef struct packed {
        logic [7:0] tens;
        logic [7:0] ones;
    } seg_pair_t;

    // Active-low seven-segment code of one decimal digit; blank above nine
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        begin
            case (digit)
                4'd0:    code = 8'hC0;
                4'd1:    code = 8'hF9;
                4'd2:    code = 8'hA4;
                4'd3:    code = 8'hB0;
                4'd4:    code = 8'h99;
                4'd5:    code = 8'h92;
                4'd6:    code = 8'h82;
                4'd7:    code = 8'hF8;
                4'd8:    code = 8'h80;
                4'd9:    code = 8'h90;
                default: code = SEG_BLANK;
            endcase
            return code;
        end
    endfunction

    // Count down, holding at zero
    function automatic logic [6:0] dec_sat(input logic [6:0] value);
        return (value == 7'd0) ? 7'd0 : value - 7'd1;
    endfunction

endpackage

>>> hdl/tlcc_seg_decode.sv
// Splits a 7-bit count into decimal digits and maps them to segment codes.
module tlcc_seg_decode
    import tlcc_pkg::*;
(
    input  logic [6:0] value,
    output seg_pair_t  seg
);

    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones_full;

    // Divide by ten through the reciprocal, then recover the remainder
    assign prod      = 15'(value) * RECIP_TEN;
    assign tens      = prod[14:RECIP_SHIFT];
    assign ones_full = value - 7'(7'(tens) * 7'd10);

    // Tens of ten or more shows blank
    assign seg.tens = seg_code(tens);
    assign seg.ones = seg_code(ones_full[3:0]);

endmodule

>>> hdl/traffic_light_countdown_controller.sv
// Two-way traffic light sequencer with countdown and seven-segment digit codes.
//
// Usage:
//   s_axis carries one tick per transfer; bit 0 of tdata is advance. Every
//   transfer produces exactly one result on m_axis: the current phase, its
//   lamp byte, both countdown values and the segment codes of their digits,
//   all taken before the tick is applied. With advance set, the counters then
//   count down and the phase moves on when its ending counter was at zero.
//   The cfg channel writes the seven registers by index; it is always ready,
//   and a write to index 7 is dropped. Second counts are masked to 7 bits.
// Output and throughput:
//   The result is registered and appears on m_axis in the cycle after the
//   tick transfer. One tick per cycle is taken as long as the result register
//   drains; the single output register sets that rate.
// Reset:
//   Phase returns to A green / B red, counters load 26 and 29, and the
//   configuration registers take their reset values. No result is pending.
// Stall:
//   While m_axis_tready is low with a result pending, s_axis_tready drops and
//   the result and the countdown state hold.
module traffic_light_countdown_controller
    import tlcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Tick input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] advance, [7:1] zero
    // Result output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [55:0] m_axis_tdata,  // [1:0] phase, [9:2] lamp_pattern,
                                       // [16:10] count_a_value, [23:17] count_b_value,
                                       // [31:24] seg_a_tens, [39:32] seg_a_ones,
                                       // [47:40] seg_b_tens, [55:48] seg_b_ones
    // Configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [6:0] green_seconds_reg;
    logic [6:0] yellow_seconds_reg;
    logic [6:0] red_seconds_reg;
    logic [7:0] lamps_a_green_reg;
    logic [7:0] lamps_a_yellow_reg;
    logic [7:0] lamps_b_green_reg;
    logic [7:0] lamps_b_yellow_reg;

    phase_t     phase_reg, phase_next;
    logic [6:0] count_a_reg, count_a_next;
    logic [6:0] count_b_reg, count_b_next;

    logic        out_valid_reg;
    logic [55:0] out_data_reg, out_data_next;

    logic       s_accept;
    logic       advance;
    logic [1:0] phase_code;
    logic [7:0] lamp_sel;
    seg_pair_t  seg_a;
    seg_pair_t  seg_b;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign advance       = s_axis_tdata[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_seconds_reg  <= GREEN_SECONDS_RST;
            yellow_seconds_reg <= YELLOW_SECONDS_RST;
            red_seconds_reg    <= RED_SECONDS_RST;
            lamps_a_green_reg  <= LAMPS_A_GREEN_RST;
            lamps_a_yellow_reg <= LAMPS_A_YELLOW_RST;
            lamps_b_green_reg  <= LAMPS_B_GREEN_RST;
            lamps_b_yellow_reg <= LAMPS_B_YELLOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GREEN_SECONDS:  green_seconds_reg  <= cfg_data[6:0];
                CFG_YELLOW_SECONDS: yellow_seconds_reg <= cfg_data[6:0];
                CFG_RED_SECONDS:    red_seconds_reg    <= cfg_data[6:0];
                CFG_LAMPS_A_GREEN:  lamps_a_green_reg  <= cfg_data;
                CFG_LAMPS_A_YELLOW: lamps_a_yellow_reg <= cfg_data;
                CFG_LAMPS_B_GREEN:  lamps_b_green_reg  <= cfg_data;
                CFG_LAMPS_B_YELLOW: lamps_b_yellow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Encode phase and pick its lamp byte
    always_comb
    begin
        case (phase_reg)
            PH_A_GREEN:
            begin
                phase_code = PHASE_CODE_A_GREEN;
                lamp_sel   = lamps_a_green_reg;
            end
            PH_A_YELLOW:
            begin
                phase_code = PHASE_CODE_A_YELLOW;
                lamp_sel   = lamps_a_yellow_reg;
            end
            PH_B_GREEN:
            begin
                phase_code = PHASE_CODE_B_GREEN;
                lamp_sel   = lamps_b_green_reg;
            end
            PH_B_YELLOW:
            begin
                phase_code = PHASE_CODE_B_YELLOW;
                lamp_sel   = lamps_b_yellow_reg;
            end
            default:
            begin
                phase_code = PHASE_CODE_A_GREEN;
                lamp_sel   = lamps_a_green_reg;
            end
        endcase
    end

    tlcc_seg_decode u_seg_a (
        .value (count_a_reg),
        .seg   (seg_a)
    );

    tlcc_seg_decode u_seg_b (
        .value (count_b_reg),
        .seg   (seg_b)
    );

    // Pack the report of the current state
    assign out_data_next = {seg_b.ones, seg_b.tens, seg_a.ones, seg_a.tens,
                            count_b_reg, count_a_reg, lamp_sel, phase_code};

    // Count down and step the phase on a tick
    always_comb
    begin
        phase_next   = phase_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (s_accept && advance)
        begin
            case (phase_reg)
                PH_A_GREEN, PH_A_YELLOW:
                begin
                    count_b_next = dec_sat(count_b_reg);
                    if (count_a_reg == 7'd0)
                    begin
                        if (phase_reg == PH_A_GREEN)
                        begin
                            phase_next   = PH_A_YELLOW;
                            count_a_next = yellow_seconds_reg;
                        end
                        else
                        begin
                            phase_next   = PH_B_GREEN;
                            count_a_next = red_seconds_reg;
                            count_b_next = green_seconds_reg;
                        end
                    end
                    else
                    begin
                        count_a_next = count_a_reg - 7'd1;
                    end
                end
                PH_B_GREEN, PH_B_YELLOW:
                begin
                    count_a_next = dec_sat(count_a_reg);
                    if (count_b_reg == 7'd0)
                    begin
                        if (phase_reg == PH_B_GREEN)
                        begin
                            phase_next   = PH_B_YELLOW;
                            count_b_next = yellow_seconds_reg;
                        end
                        else
                        begin
                            phase_next   = PH_A_GREEN;
                            count_a_next = green_seconds_reg;
                            count_b_next = red_seconds_reg;
                        end
                    end
                    else
                    begin
                        count_b_next = count_b_reg - 7'd1;
                    end
                end
                default:
                begin
                    phase_next   = PH_A_GREEN;
                    count_a_next = green_seconds_reg;
                    count_b_next = red_seconds_reg;
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_A_GREEN;
            count_a_reg <= GREEN_SECONDS_RST;
            count_b_reg <= RED_SECONDS_RST;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A tick transfer always leaves a result pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_axis_tvalid)
    else $error("no result after tick transfer");

    // State moves only on a tick transfer with advance set
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_accept && advance) |=> ($stable(phase_reg) && $stable(count_a_reg)
                                    && $stable(count_b_reg)))
    else $error("countdown state changed without a tick");

    // Out of A green, the phase only holds or steps forward to A yellow
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_A_GREEN) |=> (phase_reg == PH_A_GREEN || phase_reg == PH_A_YELLOW))
    else $error("illegal phase step out of A green");

    // In the A phases, counter A counts down by one while above zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && advance && (phase_reg == PH_A_GREEN || phase_reg == PH_A_YELLOW)
         && count_a_reg != 7'd0)
        |=> (count_a_reg == $past(count_a_reg) - 7'd1))
    else $error("A counter did not count down");

endmodule

>>> dv/tb.sv
// Testbench for the traffic light countdown controller: directed and random tick streams.
`timescale 1ns / 1ps

module tb
    import tlcc_pkg::*;
;

    // Run length guard in clock cycles
    localparam int CYCLE_LIMIT = 200000;
    // Register index past the end of the register file
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    // One report of the controller, laid out as m_axis_tdata
    typedef struct packed {
        logic [7:0] seg_b_ones;
        logic [7:0] seg_b_tens;
        logic [7:0] seg_a_ones;
        logic [7:0] seg_a_tens;
        logic [6:0] count_b;
        logic [6:0] count_a;
        logic [7:0] lamp;
        logic [1:0] phase;
    } light_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [0] advance, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [1:0] phase, [9:2] lamp_pattern,
                                        // [16:10] count_a_value, [23:17] count_b_value,
                                        // [31:24] seg_a_tens, [39:32] seg_a_ones,
                                        // [47:40] seg_b_tens, [55:48] seg_b_ones
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [7:0]  cfg_data = 8'd0;

    // Predicted controller state
    logic [1:0]  light_phase;
    logic [6:0]  secs_a;
    logic [6:0]  secs_b;
    logic [7:0]  reg_shadow [0:6];

    light_report_t pending_reports [$];
    int unsigned   fail_count = 0;
    int unsigned   cycle_count = 0;
    bit            idle_off = 1'b0;
    int unsigned   ready_hold = 0;
    bit            out_seen;
    logic [55:0]   out_word;

    traffic_light_countdown_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Active-low segment pattern of one decimal digit
    function automatic logic [7:0] digit_segments(input int unsigned digit);
        case (digit)
            0:       return 8'hC0;
            1:       return 8'hF9;
            2:       return 8'hA4;
            3:       return 8'hB0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hF8;
            8:       return 8'h80;
            9:       return 8'h90;
            default: return SEG_BLANK;
        endcase
    endfunction

    function automatic logic [6:0] count_down_hold(input logic [6:0] value);
        return (value == 7'd0) ? 7'd0 : value - 7'd1;
    endfunction

    // Build the report for one tick, then apply the tick to the predicted state
    function automatic light_report_t predict_tick(input logic adv);
        light_report_t rep;
        rep.phase      = light_phase;
        rep.lamp       = reg_shadow[CFG_LAMPS_A_GREEN + {1'b0, light_phase}];
        rep.count_a    = secs_a;
        rep.count_b    = secs_b;
        rep.seg_a_tens = digit_segments(secs_a / 10);
        rep.seg_a_ones = digit_segments(secs_a % 10);
        rep.seg_b_tens = digit_segments(secs_b / 10);
        rep.seg_b_ones = digit_segments(secs_b % 10);
        if (adv)
        begin
            if (light_phase == PHASE_CODE_A_GREEN || light_phase == PHASE_CODE_A_YELLOW)
            begin
                // A ends the phase
                secs_b = count_down_hold(secs_b);
                if (secs_a != 7'd0)
                    secs_a = secs_a - 7'd1;
                else if (light_phase == PHASE_CODE_A_GREEN)
                begin
                    light_phase = PHASE_CODE_A_YELLOW;
                    secs_a      = reg_shadow[CFG_YELLOW_SECONDS][6:0];
                end
                else
                begin
                    light_phase = PHASE_CODE_B_GREEN;
                    secs_a      = reg_shadow[CFG_RED_SECONDS][6:0];
                    secs_b      = reg_shadow[CFG_GREEN_SECONDS][6:0];
                end
            end
            else
            begin
                // B ends the phase
                secs_a = count_down_hold(secs_a);
                if (secs_b != 7'd0)
                    secs_b = secs_b - 7'd1;
                else if (light_phase == PHASE_CODE_B_GREEN)
                begin
                    light_phase = PHASE_CODE_B_YELLOW;
                    secs_b      = reg_shadow[CFG_YELLOW_SECONDS][6:0];
                end
                else
                begin
                    light_phase = PHASE_CODE_A_GREEN;
                    secs_a      = reg_shadow[CFG_GREEN_SECONDS][6:0];
                    secs_b      = reg_shadow[CFG_RED_SECONDS][6:0];
                end
            end
        end
        return rep;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_report(input logic [55:0] word);
        light_report_t got;
        light_report_t want;
        got = light_report_t'(word);
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected report, expected none, actual %0h", $time, word);
            fail_count++;
        end
        else
        begin
            want = pending_reports.pop_front();
            compare_field("phase", 8'(want.phase), 8'(got.phase));
            compare_field("lamp_pattern", want.lamp, got.lamp);
            compare_field("count_a_value", 8'(want.count_a), 8'(got.count_a));
            compare_field("count_b_value", 8'(want.count_b), 8'(got.count_b));
            compare_field("seg_a_tens", want.seg_a_tens, got.seg_a_tens);
            compare_field("seg_a_ones", want.seg_a_ones, got.seg_a_ones);
            compare_field("seg_b_tens", want.seg_b_tens, got.seg_b_tens);
            compare_field("seg_b_ones", want.seg_b_ones, got.seg_b_ones);
        end
    endtask

    // Sample the report stream before each edge, check transfers, stall at random
    always
    begin
        @(negedge clk);
        out_seen = rst_n && m_axis_tvalid && m_axis_tready;
        out_word = m_axis_tdata;
        @(posedge clk);
        if (out_seen)
        begin
            check_report(out_word);
            ready_hold = idle_off ? 0 : $urandom_range(0, 10);
        end
        if (ready_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_hold--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Send one tick; tvalid stays high afterwards until a later gap drops it or the stream is quiesced
    task automatic send_tick(input logic adv);
        int unsigned gap;
        bit          rdy;
        gap = idle_off ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, adv};
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end
        while (!rdy);
        pending_reports.push_back(predict_tick(adv));
    endtask

    // Drop tvalid and hold until every predicted report has been checked
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        if (index < CFG_UNUSED_INDEX)
            reg_shadow[index] = (index <= CFG_RED_SECONDS) ? {1'b0, data[6:0]} : data;
    endtask

    // Rewrite every register while the block is idle
    task automatic load_settings(input logic [7:0] green, input logic [7:0] yellow,
                                 input logic [7:0] red, input logic [7:0] lamp_ag,
                                 input logic [7:0] lamp_ay, input logic [7:0] lamp_bg,
                                 input logic [7:0] lamp_by);
        drain_reports();
        write_reg(CFG_LAMPS_B_YELLOW, lamp_by);
        write_reg(CFG_GREEN_SECONDS, green);
        write_reg(CFG_LAMPS_A_YELLOW, lamp_ay);
        write_reg(CFG_YELLOW_SECONDS, yellow);
        write_reg(CFG_RED_SECONDS, red);
        write_reg(CFG_LAMPS_A_GREEN, lamp_ag);
        write_reg(CFG_LAMPS_B_GREEN, lamp_bg);
        write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    // Mostly short durations, some boundary and masked values
    function automatic logic [7:0] pick_seconds();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 8'($urandom_range(0, 12));
        else if (sel < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return {$urandom_range(0, 1) == 1, 7'd0};
                1:       return {$urandom_range(0, 1) == 1, 7'd99};
                2:       return {$urandom_range(0, 1) == 1, 7'd100};
                default: return {$urandom_range(0, 1) == 1, 7'd127};
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Default registers, two report-only ticks, then advancing ticks with one more report-only tick
    task automatic test_reset_state();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Zero-length phases: once the running counts have run out, every advancing tick ends a phase
    task automatic test_zero_durations();
        int i;
        load_settings(8'd0, 8'd0, 8'd0, 8'h00, 8'hFF, 8'h55, 8'hAA);
        // Run the running counts down until both directions reload at zero
        idle_off = 1'b1;
        while (light_phase != PHASE_CODE_B_GREEN)
            send_tick(1'b1);
        idle_off = 1'b0;
        for (i = 0; i < 5; i++)
            send_tick(1'b1);
    endtask

    // Counts above 99 with masked writes, lamp bytes applied at once
    task automatic test_long_counts();
        int i;
        load_settings(8'hFF, 8'hE4, 8'd99, 8'hFF, 8'h00, 8'hAA, 8'h55);
        for (i = 0; i < 4; i++)
            send_tick(1'b1);
        send_tick(1'b0);
        for (i = 0; i < 4; i++)
            send_tick(1'b1);
    endtask

    // Random settings with long, mostly advancing tick runs
    task automatic test_random_traffic();
        int round;
        int i;
        for (round = 0; round < 6; round++)
        begin
            load_settings(pick_seconds(), pick_seconds(), pick_seconds(),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            for (i = 0; i < 215; i++)
            begin
                // Stretches with and without idle cycles, picked at random
                if (i % 40 == 0)
                    idle_off = ($urandom_range(0, 3) == 0);
                // Hold off once until the output side is empty
                if (round == 2 && i == 100)
                    drain_reports();
                send_tick($urandom_range(0, 99) < 85);
            end
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        // Registers and state after reset
        reg_shadow[CFG_GREEN_SECONDS]  = {1'b0, GREEN_SECONDS_RST};
        reg_shadow[CFG_YELLOW_SECONDS] = {1'b0, YELLOW_SECONDS_RST};
        reg_shadow[CFG_RED_SECONDS]    = {1'b0, RED_SECONDS_RST};
        reg_shadow[CFG_LAMPS_A_GREEN]  = LAMPS_A_GREEN_RST;
        reg_shadow[CFG_LAMPS_A_YELLOW] = LAMPS_A_YELLOW_RST;
        reg_shadow[CFG_LAMPS_B_GREEN]  = LAMPS_B_GREEN_RST;
        reg_shadow[CFG_LAMPS_B_YELLOW] = LAMPS_B_YELLOW_RST;
        light_phase = PHASE_CODE_A_GREEN;
        secs_a      = GREEN_SECONDS_RST;
        secs_b      = RED_SECONDS_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_durations();
        test_long_counts();
        test_random_traffic();

        drain_reports();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
